FILE: rtl/sgs_pkg.sv
package sgs_pkg;

	// Sample format: signed Q4.12
	localparam int SampleBits = 16;
	localparam int FracBits   = 12;

	// Accumulator: signed Q24.24, saturating
	localparam int AccBits    = 48;

	// Gate: unsigned Q0.16 held in 17 bits (0 .. 65536)
	localparam int GateBits   = 17;

	// Sigmoid table over logits in [-8, 8); entry count is a power of two
	localparam int SigEntries = 256;
	localparam int SigIdxBits = $clog2(SigEntries);

	// Logit clamp window in accumulator units (2^24 per unit)
	localparam logic signed [AccBits-1:0] LogitMin = -(48'sd1 <<< 27);
	localparam logic signed [AccBits-1:0] LogitMax = (48'sd1 <<< 27) - 48'sd1;

	typedef enum logic {
		CmdTerm = 1'b0,
		CmdElem = 1'b1
	} sgs_cmd_t;

	typedef struct packed {
		sgs_cmd_t                      command;
		logic signed [SampleBits-1:0]  weight;
		logic signed [SampleBits-1:0]  x_value;
		logic signed [SampleBits-1:0]  bias;
		logic                          last_term;
		logic signed [SampleBits-1:0]  attn_value;
		logic                          last_element;
	} sgs_in_t;

	typedef struct packed {
		logic signed [SampleBits-1:0]  gated_value;
		logic                          last;
	} sgs_out_t;

	// Pipeline load enables and stage occupancy, from the top level
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_out;
		logic vld_s2;
		logic vld_s3;
	} sgs_ctrl_t;

	typedef logic [GateBits-1:0] sig_table_t [SigEntries];

	// Restoring shift-subtract quotient, non-negative operands
	function automatic longint div_nonneg(input longint num, input longint den);
		longint q;
		longint r;
		q = 0;
		r = 0;
		for (int b = 62; b >= 0; b--) begin
			r = (r <<< 1) | ((num >>> b) & 64'sd1);
			q = q <<< 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'sd1;
			end
		end
		return q;
	endfunction

	// e^-y in Q30 for y in Q30, 0 <= y <= 8 * 2^30
	function automatic longint exp_neg_q30(input longint y);
		longint z;
		longint term;
		longint sum;
		z    = y >>> 4;
		term = 64'sd1 <<< 30;
		sum  = term;
		for (int k = 1; k <= 12; k++) begin
			term = div_nonneg((term * z) >>> 30, longint'(k));
			sum  = k[0] ? (sum - term) : (sum + term);
		end
		for (int k = 0; k < 4; k++) begin
			sum = (sum * sum) >>> 30;
		end
		return sum;
	endfunction

	// Midpoint-sampled sigmoid, round half up, Q0.16
	function automatic sig_table_t build_sig_table();
		sig_table_t tbl;
		longint     x;
		longint     y;
		longint     e;
		longint     d;
		longint     g;
		for (int i = 0; i < SigEntries; i++) begin
			x = -(64'sd1 <<< 33) +
				(((64'sd1 <<< 33) * longint'(2 * i + 1)) >>> SigIdxBits);
			y = (x < 0) ? -x : x;
			e = exp_neg_q30(y);
			d = (64'sd1 <<< 30) + e;
			if (x >= 0) begin
				g = div_nonneg((64'sd1 <<< 46) + (d >>> 1), d);
			end else begin
				g = div_nonneg((e <<< 16) + (d >>> 1), d);
			end
			tbl[i] = g[GateBits-1:0];
		end
		return tbl;
	endfunction

	localparam sig_table_t SigTable = build_sig_table();

endpackage

FILE: rtl/sigmoid_gated_scaling.sv
// Throughput: one transaction per cycle, terms and elements alike, while
//   result_stall does not back up the pipeline; set by the single saturating
//   48-bit accumulate at stage 2, whose result feeds back.
// Reset (arst_n low, asynchronous): pipeline empty, accumulator and gate zero,
//   next term takes the bias. The sigmoid table is constant logic.
module sigmoid_gated_scaling (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  sgs_pkg::sgs_in_t  item,
	output logic              result_valid,
	input  logic              result_stall,
	output sgs_pkg::sgs_out_t result
);

	// Five register stages:
	//   s1  input register
	//   s2  weight * x product (gate path)
	//   s3  saturated accumulator value; sigmoid lookup into the gate at exit
	//   s4  element * gate + half LSB (elements only)
	//   out saturated Q4.12 result register
	// Each stage loads when it is empty or its content moves on, so bubbles
	// collapse and a stalled result does not block upstream stages with room.

	sgs_pkg::sgs_in_t   item_s1;
	logic               vld_s1;
	logic               vld_s2;
	logic               vld_s3;
	logic               vld_s4;
	logic               result_valid_q;

	logic               ld_s1;
	logic               ld_s2;
	logic               ld_s3;
	logic               ld_s4;
	logic               ld_out;

	sgs_pkg::sgs_ctrl_t ctrl;

	logic [sgs_pkg::GateBits-1:0]          gate;
	logic                                  elem_s3;
	logic signed [sgs_pkg::SampleBits-1:0] attn_s3;
	logic                                  last_s3;

	// load chain, output side first
	assign ld_out = !result_valid_q || !result_stall;
	assign ld_s4  = !vld_s4 || ld_out;
	assign ld_s3  = !vld_s3 || ld_s4;
	assign ld_s2  = !vld_s2 || ld_s3;
	assign ld_s1  = !vld_s1 || ld_s2;

	assign item_stall = !ld_s1;

	always_comb begin
		ctrl.ld_s2  = ld_s2;
		ctrl.ld_s3  = ld_s3;
		ctrl.ld_s4  = ld_s4;
		ctrl.ld_out = ld_out;
		ctrl.vld_s2 = vld_s2;
		ctrl.vld_s3 = vld_s3;
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			item_s1 <= item;
		end
	end

	// stage occupancy; gate terms drop out after stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			vld_s3         <= 1'b0;
			vld_s4         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (ld_s1) begin
				vld_s1 <= item_valid;
			end
			if (ld_s2) begin
				vld_s2 <= vld_s1;
			end
			if (ld_s3) begin
				vld_s3 <= vld_s2;
			end
			if (ld_s4) begin
				vld_s4 <= vld_s3 && elem_s3;
			end
			if (ld_out) begin
				result_valid_q <= vld_s4;
			end
		end
	end

	sgs_gate u_gate (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.item_s1 (item_s1),
		.gate    (gate),
		.elem_s3 (elem_s3),
		.attn_s3 (attn_s3),
		.last_s3 (last_s3)
	);

	sgs_scale u_scale (
		.clk     (clk),
		.ctrl    (ctrl),
		.gate    (gate),
		.attn_s3 (attn_s3),
		.last_s3 (last_s3),
		.result  (result)
	);

	assign result_valid = result_valid_q;

	// input stalls only when the input register holds a transaction
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> vld_s1)
		else $error("input stalled with an empty input register");

	// a new result comes only from an element in stage 4
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(vld_s4))
		else $error("result appeared without a stage 4 element");

	// a blocked stage 4 element is kept
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !ld_out) |=> vld_s4)
		else $error("stage 4 element lost while output blocked");

endmodule

FILE: rtl/sgs_gate.sv
// Gate path: term product, bias + dot accumulation, sigmoid lookup.
module sgs_gate (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sgs_pkg::sgs_ctrl_t                   ctrl,
	input  sgs_pkg::sgs_in_t                     item_s1,
	output logic [sgs_pkg::GateBits-1:0]         gate,
	output logic                                 elem_s3,
	output logic signed [sgs_pkg::SampleBits-1:0] attn_s3,
	output logic                                 last_s3
);

	// stage 2
	sgs_pkg::sgs_cmd_t                        cmd_s2;
	logic                                     last_term_s2;
	logic signed [2*sgs_pkg::SampleBits-1:0]  prod_s2;
	logic signed [sgs_pkg::SampleBits-1:0]    bias_s2;
	logic signed [sgs_pkg::SampleBits-1:0]    attn_s2;
	logic                                     last_el_s2;

	// stage 3
	sgs_pkg::sgs_cmd_t                        cmd_s3;
	logic                                     look_s3;
	logic signed [sgs_pkg::AccBits-1:0]       acc_s3;

	// state
	logic signed [sgs_pkg::AccBits-1:0]       acc_q;
	logic                                     term_open_q;
	logic [sgs_pkg::GateBits-1:0]             gate_q;

	logic signed [sgs_pkg::AccBits-1:0]       acc_base;
	logic signed [sgs_pkg::AccBits:0]         acc_sum;
	logic signed [sgs_pkg::AccBits-1:0]       acc_next;
	logic [27:0]                              logit_ofs;
	logic [sgs_pkg::SigIdxBits-1:0]           sig_idx;
	logic                                     acc_upd;
	logic                                     gate_upd;

	// bias enters on the first term of a run, scaled to Q24.24
	assign acc_base = term_open_q ? acc_q :
		{{(sgs_pkg::AccBits-sgs_pkg::SampleBits-sgs_pkg::FracBits){bias_s2[sgs_pkg::SampleBits-1]}},
		 bias_s2, {sgs_pkg::FracBits{1'b0}}};

	assign acc_sum = {acc_base[sgs_pkg::AccBits-1], acc_base} +
		{{(sgs_pkg::AccBits+1-2*sgs_pkg::SampleBits){prod_s2[2*sgs_pkg::SampleBits-1]}}, prod_s2};

	always_comb begin
		if (acc_sum[sgs_pkg::AccBits] != acc_sum[sgs_pkg::AccBits-1]) begin
			acc_next = acc_sum[sgs_pkg::AccBits] ?
				{1'b1, {(sgs_pkg::AccBits-1){1'b0}}} :
				{1'b0, {(sgs_pkg::AccBits-1){1'b1}}};
		end else begin
			acc_next = acc_sum[sgs_pkg::AccBits-1:0];
		end
	end

	// clamp to [-8, 8) and shift to an unsigned offset
	always_comb begin
		if (acc_s3 < sgs_pkg::LogitMin) begin
			logit_ofs = '0;
		end else if (acc_s3 > sgs_pkg::LogitMax) begin
			logit_ofs = '1;
		end else begin
			logit_ofs = {~acc_s3[27], acc_s3[26:0]};
		end
	end

	assign sig_idx  = logit_ofs[27 -: sgs_pkg::SigIdxBits];
	assign acc_upd  = ctrl.ld_s3 && ctrl.vld_s2 && (cmd_s2 == sgs_pkg::CmdTerm);
	assign gate_upd = ctrl.ld_s4 && ctrl.vld_s3 && (cmd_s3 == sgs_pkg::CmdTerm) && look_s3;

	always_ff @(posedge clk) begin
		if (ctrl.ld_s2) begin
			cmd_s2       <= item_s1.command;
			last_term_s2 <= item_s1.last_term;
			prod_s2      <= item_s1.weight * item_s1.x_value;
			bias_s2      <= item_s1.bias;
			attn_s2      <= item_s1.attn_value;
			last_el_s2   <= item_s1.last_element;
		end
		if (ctrl.ld_s3) begin
			cmd_s3  <= cmd_s2;
			look_s3 <= last_term_s2;
			acc_s3  <= acc_next;
			attn_s3 <= attn_s2;
			last_s3 <= last_el_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			term_open_q <= 1'b0;
			gate_q      <= '0;
		end else begin
			if (acc_upd) begin
				acc_q       <= acc_next;
				term_open_q <= !last_term_s2;
			end
			if (gate_upd) begin
				gate_q <= sgs_pkg::SigTable[sig_idx];
			end
		end
	end

	assign gate    = gate_q;
	assign elem_s3 = (cmd_s3 == sgs_pkg::CmdElem);

	// gate moves only when a closing term leaves stage 3
	a_gate_src: assert property (@(posedge clk) disable iff (!arst_n)
		(gate_q != $past(gate_q)) |-> $past(gate_upd))
		else $error("gate changed without a closing term");

endmodule

FILE: rtl/sgs_scale.sv
// Element path: multiply by gate, round, saturate to Q4.12.
module sgs_scale (
	input  logic                                  clk,
	input  sgs_pkg::sgs_ctrl_t                    ctrl,
	input  logic [sgs_pkg::GateBits-1:0]          gate,
	input  logic signed [sgs_pkg::SampleBits-1:0] attn_s3,
	input  logic                                  last_s3,
	output sgs_pkg::sgs_out_t                     result
);

	localparam int ProdBits = sgs_pkg::SampleBits + sgs_pkg::GateBits + 1;
	localparam int ShBits   = ProdBits - 16;

	logic signed [sgs_pkg::GateBits:0]    gate_sx;
	logic signed [ProdBits-1:0]           mul;
	logic signed [ProdBits-1:0]           prod_s4;
	logic                                 last_s4;
	logic signed [ShBits-1:0]             shifted;
	logic signed [sgs_pkg::SampleBits-1:0] sat;
	sgs_pkg::sgs_out_t                    result_q;

	assign gate_sx = {1'b0, gate};
	assign mul     = attn_s3 * gate_sx;

	// floor shift of the rounded product
	assign shifted = prod_s4[ProdBits-1:16];

	always_comb begin
		if (shifted > ShBits'(2**(sgs_pkg::SampleBits-1) - 1)) begin
			sat = {1'b0, {(sgs_pkg::SampleBits-1){1'b1}}};
		end else if (shifted < -(ShBits'(2**(sgs_pkg::SampleBits-1)))) begin
			sat = {1'b1, {(sgs_pkg::SampleBits-1){1'b0}}};
		end else begin
			sat = shifted[sgs_pkg::SampleBits-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_s4) begin
			prod_s4 <= mul + ProdBits'(32768);
			last_s4 <= last_s3;
		end
		if (ctrl.ld_out) begin
			result_q.gated_value <= sat;
			result_q.last        <= last_s4;
		end
	end

	assign result = result_q;

endmodule
